[src/ssrch_pkg.sv]
// Package with the shared types and constants of the streaming substring search.
`default_nettype none

package ssrch_pkg;

  // Sizes of the search window and of the position counter.
  localparam int unsigned PATTERN_MAX   = 8;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned OFFSET_W      = 16;
  localparam int unsigned POS_FIELD_W   = 16;
  localparam int unsigned PAT_IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned CMP_W         = (POSITION_BITS > OFFSET_W) ? POSITION_BITS
                                                                     : OFFSET_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // Register port.
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned REG_W   = 2;

  localparam logic [REG_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [REG_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [REG_W-1:0] REG_START_OFFSET   = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic                   found;
    logic [POS_FIELD_W-1:0] position;
  } out_word_t;

  typedef struct packed {
    logic [PATTERN_MAX*BYTE_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]              pattern_length;
    logic [OFFSET_W-1:0]           start_offset;
  } cfg_t;

endpackage

`default_nettype wire

[src/ssrch_cell.sv]
// One window cell: holds one text byte, passes it on and compares the byte entering it to its pattern byte.
`default_nettype none

module ssrch_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        shift_i,
  input  wire logic                        clear_i,
  input  wire logic [ssrch_pkg::BYTE_W-1:0] byte_i,
  input  wire logic [ssrch_pkg::BYTE_W-1:0] want_i,
  input  wire logic                        use_i,
  output logic      [ssrch_pkg::BYTE_W-1:0] byte_o,
  output logic                             hit_o
);
  import ssrch_pkg::*;

  logic [BYTE_W-1:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (clear_i) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // The check looks at the window as it stands after the incoming shift.
  assign hit_o  = !use_i || (byte_i == want_i);
  assign byte_o = byte_q;

endmodule

`default_nettype wire

[src/ssrch_regs.sv]
// Configuration registers behind the APB-style port.
`default_nettype none

module ssrch_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ssrch_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ssrch_pkg::DATA_W-1:0]  pwdata,
  output logic      [ssrch_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output ssrch_pkg::cfg_t                   cfg_o
);
  import ssrch_pkg::*;

  cfg_t             cfg_q;
  cfg_t             cfg_d;
  logic [REG_W-1:0] reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:PADDR_W-REG_W];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_BYTES:  cfg_d.pattern_bytes  = pwdata[PATTERN_MAX*BYTE_W-1:0];
        REG_PATTERN_LENGTH: cfg_d.pattern_length = pwdata[LEN_W-1:0];
        REG_START_OFFSET:   cfg_d.start_offset   = pwdata[OFFSET_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_BYTES:  prdata = DATA_W'(cfg_q.pattern_bytes);
      REG_PATTERN_LENGTH: prdata = DATA_W'(cfg_q.pattern_length);
      REG_START_OFFSET:   prdata = DATA_W'(cfg_q.start_offset);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/substring_search_stream.sv]
// Top level of the streaming substring search: window cell chain, match tracking, result register.
`default_nettype none

// Streaming first-occurrence substring search. Text arrives one byte per input
// word, and the word that carries last closes the text. The block reports, in one
// output word per text, whether the configured pattern (one to eight bytes) occurs
// starting at a position at or above start_offset, and the start position of the
// first such occurrence; position is zero when nothing was found. A pattern length
// of zero or above eight never matches, and neither does a pattern longer than the
// text. A row of eight byte cells forms the search window: every accepted byte
// shifts into the first cell and moves one cell further on each later byte, while
// every cell compares its byte with the pattern byte assigned to it, so the match
// that ends on the incoming byte is checked in the same cycle that takes the byte.
// The block therefore takes one byte per clock cycle. The result of a text is
// captured in the output register at the clock edge that takes its last byte and
// is offered from the next cycle on. While a finished result waits in the output
// register with out_ready_i low, the input stalls, so any byte waits until the
// result has been taken. The position counter saturates at 65535; matches that
// would end beyond that index are ignored. After the last byte the window, counter
// and match state clear for the next text, while the configuration registers keep
// their values. Write the registers only while no text is in progress.
module substring_search_stream (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Text input.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  ssrch_pkg::in_word_t               in_word_i,
  // Result output.
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output ssrch_pkg::out_word_t              out_word_o,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ssrch_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ssrch_pkg::DATA_W-1:0]  pwdata,
  output logic      [ssrch_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import ssrch_pkg::*;

  cfg_t                     cfg;
  logic                     accept;
  logic                     close_text;
  logic [BYTE_W-1:0]        chain   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]   hits;
  logic                     len_ok;
  logic                     all_hit;
  logic [POSITION_BITS:0]   end_plus_one;
  logic                     reach;
  logic [POSITION_BITS-1:0] start_pos;
  logic                     after_offset;
  logic                     take_match;

  logic [POSITION_BITS-1:0] byte_count_q, byte_count_d;
  logic                     past_max_q, past_max_d;
  logic                     match_seen_q, match_seen_d;
  logic [POSITION_BITS-1:0] match_start_q, match_start_d;
  logic                     out_valid_q, out_valid_d;
  out_word_t                out_word_q, out_word_d;

  ssrch_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A new byte can enter whenever the output register is free or is being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign close_text = accept && in_word_i.last;

  assign len_ok = (cfg.pattern_length != '0) &&
                  (32'(cfg.pattern_length) <= PATTERN_MAX);

  assign chain[0] = in_word_i.text_byte;

  // Cell k sees the byte k places back from the incoming one. For a pattern of
  // length n it must equal pattern byte n-1-k, and cells at k >= n take no part.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [LEN_W-1:0]     pat_idx;
    logic [PAT_IDX_W-1:0] pat_sel;
    logic [BYTE_W-1:0]    want;
    logic                 use_cell;
    logic [BYTE_W-1:0]    held;

    assign pat_idx  = cfg.pattern_length - LEN_W'(k + 1);
    assign pat_sel  = pat_idx[PAT_IDX_W-1:0];
    assign want     = cfg.pattern_bytes[BYTE_W*pat_sel +: BYTE_W];
    assign use_cell = (32'(cfg.pattern_length) > k);

    ssrch_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .clear_i (close_text),
      .byte_i  (chain[k]),
      .want_i  (want),
      .use_i   (use_cell),
      .byte_o  (held),
      .hit_o   (hits[k])
    );

    if (k < PATTERN_MAX - 1) begin : g_link
      assign chain[k+1] = held;
    end
  end

  assign all_hit = &hits;

  // The candidate ends on the incoming byte, so it starts at count + 1 - n.
  assign end_plus_one = {1'b0, byte_count_q} + 1'b1;
  assign reach        = end_plus_one >= (POSITION_BITS+1)'(cfg.pattern_length);
  assign start_pos    = POSITION_BITS'(end_plus_one - (POSITION_BITS+1)'(cfg.pattern_length));
  assign after_offset = CMP_W'(start_pos) >= CMP_W'(cfg.start_offset);
  assign take_match   = accept && !match_seen_q && !past_max_q && len_ok &&
                        reach && after_offset && all_hit;

  always_comb begin
    match_seen_d  = match_seen_q || take_match;
    match_start_d = take_match ? start_pos : match_start_q;
    byte_count_d  = byte_count_q;
    past_max_d    = past_max_q;
    if (accept) begin
      if (byte_count_q == POS_MAX) begin
        past_max_d = 1'b1;
      end else begin
        byte_count_d = byte_count_q + 1'b1;
      end
    end

    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (close_text) begin
      out_valid_d          = 1'b1;
      out_word_d.found     = match_seen_d;
      out_word_d.position  = match_seen_d ? POS_FIELD_W'(CMP_W'(match_start_d)) : '0;
      // The stream state starts over for the next text.
      match_seen_d  = 1'b0;
      match_start_d = '0;
      byte_count_d  = '0;
      past_max_d    = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      past_max_q    <= 1'b0;
      match_seen_q  <= 1'b0;
      match_start_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      byte_count_q  <= byte_count_d;
      past_max_q    <= past_max_d;
      match_seen_q  <= match_seen_d;
      match_start_q <= match_start_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
